@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SWM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("swm assertion failed");
`define SWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("swm assertion failed");
`else
`define SWM_ASSERT(lbl, clk, rstn, prop)
`define SWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/swm_pkg.sv @@
package swm_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int WLEN_BITS   = 7;
  localparam int PTR_BITS    = $clog2(MAX_WINDOW);
  localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);
  localparam int CMP_BITS    = (CNT_BITS > WLEN_BITS) ? CNT_BITS : WLEN_BITS;

  typedef logic [PTR_BITS-1:0] ptr_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  typedef struct packed {
    logic load_item;
    logic evict;
    logic rd_back;
    logic pop;
    logic push;
    logic load_out;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic pop_hit;
    logic out_free;
    logic last;
  } status_t;

  function automatic ptr_t ring_next(input ptr_t p);
    return (p == PTR_BITS'(MAX_WINDOW - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t ring_prev(input ptr_t p);
    return (p == '0) ? PTR_BITS'(MAX_WINDOW - 1) : ptr_t'(p - 1'b1);
  endfunction

endpackage

@@ rtl/swm_if.sv @@
interface swm_in_if import swm_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] window_min;

  modport source (output valid, output window_min, input ready);
  modport sink   (input valid, input window_min, output ready);
endinterface

interface swm_cfg_if import swm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WLEN_BITS-1:0] window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

@@ rtl/swm_ram.sv @@
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/swm_ctrl.sv @@
module swm_ctrl import swm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT,
    ST_POP,
    ST_PUSH,
    ST_RDMIN,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_EVICT;
        end
      end
      ST_EVICT: begin
        cmd.evict   = 1'b1;
        cmd.rd_back = 1'b1;
        state_nxt   = ST_POP;
      end
      ST_POP: begin
        if (status.pop_hit) begin
          cmd.pop     = 1'b1;
          cmd.rd_back = 1'b1;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = ST_RDMIN;
      end
      ST_RDMIN: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!status.full) begin
          cmd.clear = status.last;
          state_nxt = ST_IDLE;
        end else if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.clear    = status.last;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/swm_dp.sv @@
`include "assert_macros.svh"

module swm_dp import swm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  output status_t                       status,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last,
  input  logic                          cfg_we,
  input  logic [WLEN_BITS-1:0]          cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_data
);

  logic [WLEN_BITS-1:0]          win_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          last_r;
  ptr_t                          hist_pos_r, front_r, back_r;
  ptr_t                          front_nxt, back_nxt, hist_pos_nxt;
  cnt_t                          count_r, count_nxt, seen_r, seen_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_data_r;

  logic [CMP_BITS-1:0]    win_ext;
  cnt_t                   weff;
  ptr_t                   old_idx, cand_raddr;
  logic [SAMPLE_BITS-1:0] hist_q, cand_q;
  logic                   full, evict_hit, clear;
  cnt_t                   ring_gap, count_mod;

  // clamp window length into 1..MAX_WINDOW
  always_comb begin
    win_ext = CMP_BITS'(win_r);
    if (win_ext == '0) begin
      weff = cnt_t'(1);
    end else if (win_ext > CMP_BITS'(MAX_WINDOW)) begin
      weff = CNT_BITS'(MAX_WINDOW);
    end else begin
      weff = CNT_BITS'(win_ext);
    end
  end

  assign full = (seen_r >= weff);

  always_comb begin
    if (cnt_t'(hist_pos_r) >= weff) begin
      old_idx = PTR_BITS'(cnt_t'(hist_pos_r) - weff);
    end else begin
      old_idx = PTR_BITS'(cnt_t'(hist_pos_r) + CNT_BITS'(MAX_WINDOW) - weff);
    end
  end

  assign evict_hit = full && (count_r != '0) && (cand_q == hist_q);
  assign clear     = cmd.clear || cfg_we;

  always_comb begin
    front_nxt     = front_r;
    back_nxt      = back_r;
    hist_pos_nxt  = hist_pos_r;
    count_nxt     = count_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.evict) begin
      if (evict_hit) begin
        front_nxt = ring_next(front_r);
        count_nxt = cnt_t'(count_r - 1'b1);
      end
      hist_pos_nxt = ring_next(hist_pos_r);
      if (seen_r < CNT_BITS'(MAX_WINDOW)) begin
        seen_nxt = cnt_t'(seen_r + 1'b1);
      end
    end
    if (cmd.pop) begin
      back_nxt  = ring_prev(back_r);
      count_nxt = cnt_t'(count_r - 1'b1);
    end
    if (cmd.push) begin
      back_nxt = ring_next(back_r);
      if (count_r == CNT_BITS'(MAX_WINDOW)) begin
        front_nxt = ring_next(front_r);
      end else begin
        count_nxt = cnt_t'(count_r + 1'b1);
      end
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
    if (clear) begin
      front_nxt    = '0;
      back_nxt     = '0;
      hist_pos_nxt = '0;
      count_nxt    = '0;
      seen_nxt     = '0;
    end
  end

  assign cand_raddr = cmd.rd_back ? ring_prev(back_nxt) : front_r;

  swm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WINDOW)) u_hist_ram (
    .clk   (clk),
    .we    (cmd.evict),
    .waddr (hist_pos_r),
    .wdata (sample_r),
    .raddr (old_idx),
    .rdata (hist_q)
  );

  swm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WINDOW)) u_cand_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (back_r),
    .wdata (sample_r),
    .raddr (cand_raddr),
    .rdata (cand_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WLEN_BITS'(1);
      front_r     <= '0;
      back_r      <= '0;
      hist_pos_r  <= '0;
      count_r     <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_r <= cfg_data;
      end
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      hist_pos_r  <= hist_pos_nxt;
      count_r     <= count_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.load_item) begin
        last_r <= in_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      sample_r <= in_sample;
    end
    if (cmd.load_out) begin
      out_data_r <= $signed(cand_q);
    end
  end

  assign status.full     = full;
  assign status.pop_hit  = (count_r != '0) && ($signed(cand_q) > sample_r);
  assign status.out_free = !out_valid_r || out_ready;
  assign status.last     = last_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // occupied span between the deque pointers
  always_comb begin
    if (back_r >= front_r) begin
      ring_gap = cnt_t'(back_r - front_r);
    end else begin
      ring_gap = cnt_t'(cnt_t'(back_r) + CNT_BITS'(MAX_WINDOW) - cnt_t'(front_r));
    end
    count_mod = (count_r == CNT_BITS'(MAX_WINDOW)) ? '0 : count_r;
  end

  `SWM_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_BITS'(MAX_WINDOW))
  `SWM_ASSERT(a_ring_span, clk, rst_n, ring_gap == count_mod)
  `SWM_ASSERT_NEXT(a_clear, clk, rst_n, clear, (count_r == '0) && (seen_r == '0))

endmodule

@@ rtl/sliding_window_minimum_core.sv @@
// Channel  Dir  Handshake        Word
// in_ch    in   valid / ready    sample (32b signed), last_sample
// out_ch   out  valid / ready    window_min (32b signed)
// cfg_ch   in   valid / ready    window_length (7b)
//
// Per sample: load, evict, pop back entries > sample, push, read min, result.
// The back-pop loop reads one deque entry per cycle from a registered-read RAM.
// The result register frees the input side; a stalled result holds the block
// in its final step until out_ch.ready.
// Reset (rst_n, sync) empties the deque and sets window_length to 1; no RAM sweep.
module sliding_window_minimum_core import swm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  swm_in_if.sink     in_ch,
  swm_out_if.source  out_ch,
  swm_cfg_if.sink    cfg_ch
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    cfg_we;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  swm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_sample (in_ch.sample),
    .in_last   (in_ch.last_sample),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_ch.window_length),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.window_min)
  );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import swm_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  typedef struct {
    smp_t value;
    bit   last;
  } word_t;

  logic clk;
  logic rst_n;

  swm_in_if  in_if();
  swm_out_if out_if();
  swm_cfg_if cfg_if();

  sliding_window_minimum_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  word_t sample_q[$];
  smp_t  win_min_q[$];
  int    err_cnt;
  int    sent_n;
  int    got_n;
  int    made_n;
  bit    in_took;

  // predictor state
  logic [WLEN_BITS-1:0] wlen_reg;
  smp_t                 hist_mem[MAX_WINDOW];
  smp_t                 cand_mem[MAX_WINDOW];
  ptr_t                 head_p;
  ptr_t                 tail_p;
  ptr_t                 wr_p;
  int unsigned          cand_n;
  int unsigned          seen_n;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned eff_len(input logic [WLEN_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_WINDOW) return MAX_WINDOW;
    return v;
  endfunction

  function automatic void clear_window();
    head_p = '0;
    tail_p = '0;
    wr_p   = '0;
    cand_n = 0;
    seen_n = 0;
  endfunction

  function automatic bit step_window_min(input smp_t s, input bit last, output smp_t m);
    int unsigned w;
    ptr_t        idx;
    bit          hit;
    w = eff_len(wlen_reg);
    if (seen_n >= w) begin
      idx = wr_p - ptr_t'(w);
      if (cand_n > 0 && cand_mem[head_p] == hist_mem[idx]) begin
        head_p++;
        cand_n--;
      end
    end
    hist_mem[wr_p] = s;
    wr_p++;
    if (seen_n < MAX_WINDOW) seen_n++;
    while (cand_n > 0 && cand_mem[ptr_t'(tail_p - 1'b1)] > s) begin
      tail_p--;
      cand_n--;
    end
    if (cand_n >= MAX_WINDOW) begin
      head_p++;
      cand_n--;
    end
    cand_mem[tail_p] = s;
    tail_p++;
    cand_n++;
    hit = (seen_n >= w);
    m = cand_mem[head_p];
    if (last) clear_window();
    return hit;
  endfunction

  // scoreboard: results checked before the same-edge input updates the predictor
  always @(posedge clk) begin : chk
    smp_t m;
    smp_t e;
    in_took <= in_if.valid && in_if.ready;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got_n++;
        if (win_min_q.size() == 0) begin
          err_cnt++;
          $display("%0t: window_min expected none, actual %0d", $time, out_if.window_min);
        end else begin
          e = win_min_q.pop_front();
          if (out_if.window_min !== e) begin
            err_cnt++;
            $display("%0t: window_min expected %0d, actual %0d", $time, e,
                     out_if.window_min);
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        wlen_reg = cfg_if.window_length;
        clear_window();
      end
      if (in_if.valid && in_if.ready) begin
        sent_n++;
        if (step_window_min(in_if.sample, in_if.last_sample, m)) win_min_q.push_back(m);
      end
    end
  end

  always @(negedge clk) begin : drv
    bit    v;
    bit    quiet;
    word_t w;
    quiet = (sent_n >= 500 && sent_n < 800);
    v = in_if.valid;
    if (v && in_took) v = 1'b0;
    if (rst_n && !v && sample_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
      w = sample_q.pop_front();
      in_if.sample      <= w.value;
      in_if.last_sample <= w.last;
      v = 1'b1;
    end
    in_if.valid <= v;
  end

  // result sink, with one long hold-off to back the block up
  int hold_left;
  bit held_once;

  always @(negedge clk) begin : snk
    bit r;
    if (!rst_n) begin
      r = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      r = 1'b0;
    end else if (!held_once && got_n >= 120) begin
      held_once = 1'b1;
      hold_left = 400;
      r = 1'b0;
    end else if (got_n >= 400 && got_n < 700) begin
      r = 1'b1;
    end else begin
      r = ($urandom_range(0, 99) >= 10);
    end
    out_if.ready <= r;
  end

  task automatic settle();
    while (sample_q.size() != 0 || in_if.valid || win_min_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_len(input logic [WLEN_BITS-1:0] v);
    settle();
    @(negedge clk);
    cfg_if.window_length <= v;
    cfg_if.valid         <= 1'b1;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic push_word(input smp_t v, input bit last);
    word_t w;
    w.value = v;
    w.last  = last;
    sample_q.push_back(w);
    made_n++;
  endtask

  // mode: 0 random, 1 narrow range, 2 rising ramp, 3 falling ramp, 4 extremes
  task automatic add_seq(input int len, input bit close, input int mode);
    int   base;
    smp_t v;
    base = int'($urandom_range(0, 2000000)) - 1000000;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: v = $urandom;
        1: v = $signed($urandom_range(0, 8)) - 4;
        2: begin
          if ($urandom_range(0, 23) == 0) v = base - 5000;
          else v = base + i * int'($urandom_range(0, 3));
        end
        3: v = base - i;
        default: begin
          case ($urandom_range(0, 5))
            0: v = 32'sh7FFF_FFFF;
            1: v = 32'sh8000_0000;
            2: v = 32'sh0;
            3: v = -32'sd1;
            4: v = 32'sh7FFF_FFFE;
            default: v = 32'sh8000_0001;
          endcase
        end
      endcase
      push_word(v, close && (i == len - 1));
    end
  endtask

  initial begin : stim
    int          wl_list[$];
    int          ph;
    int          w;
    int unsigned ew;
    int          nseq;
    int          len;
    wl_list = '{64, 1, 0, 127, 2, 65, 3};
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.sample         = '0;
    in_if.last_sample    = 1'b0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.window_length = '0;
    wlen_reg             = 7'd1;
    clear_window();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // window of one after reset: extremes and last flags
    push_word(32'sh7FFF_FFFF, 1'b0);
    push_word(32'sh8000_0000, 1'b0);
    push_word(32'sh0, 1'b0);
    push_word(-32'sd1, 1'b0);
    push_word(32'sh8000_0000, 1'b1);
    push_word(32'sh7FFF_FFFF, 1'b1);
    push_word(32'sd5, 1'b0);

    // window of three: filling, equal values kept, eviction, clear on last
    write_len(7'd3);
    push_word(32'sd10, 1'b0);
    push_word(32'sd20, 1'b0);
    push_word(32'sd5, 1'b0);
    push_word(32'sd5, 1'b0);
    push_word(32'sd30, 1'b0);
    push_word(32'sd40, 1'b0);
    push_word(32'sd50, 1'b0);
    push_word(32'sh8000_0000, 1'b0);
    push_word(32'sd1, 1'b1);
    push_word(32'sd7, 1'b0);
    push_word(32'sd8, 1'b0);
    push_word(32'sd9, 1'b0);
    push_word(32'sh7FFF_FFFF, 1'b0);

    ph = 0;
    while (made_n < 1350) begin
      if (ph < wl_list.size()) w = wl_list[ph];
      else if ($urandom_range(0, 3) == 0) w = $urandom_range(1, 4);
      else w = $urandom_range(1, 64);
      ph++;
      write_len(w[WLEN_BITS-1:0]);
      ew = eff_len(w[WLEN_BITS-1:0]);
      nseq = $urandom_range(2, 5);
      for (int k = 0; k < nseq && made_n < 1350; k++) begin
        if ($urandom_range(0, 9) < 2) len = $urandom_range(1, ew);
        else len = ew + $urandom_range(0, ew + 16);
        if (len > 1350 - made_n) len = 1350 - made_n;
        add_seq(len, (k < nseq - 1) || $urandom_range(0, 1), $urandom_range(0, 4));
      end
    end

    settle();
    if (err_cnt == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin : watchdog
    #(10_000_000);
    $display("tb: errors");
    $finish;
  end

endmodule
